@@ hw/rtl/bsa_pkg.sv @@
// Package for the ascending bubble sorter: item/result structs, widths, FSM codes.
// No dependencies.
`default_nettype none

package bsa_pkg;

    localparam int DATA_W = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last_item;
    } t_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_result;
        logic                     overflow;
    } t_result;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD0  = 6'b000010,
        S_LD   = 6'b000100,
        S_RUN  = 6'b001000,
        S_END  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    // Result of one neighbor compare: smaller goes back to memory, larger moves on
    typedef struct packed {
        logic signed [DATA_W-1:0] low;
        logic signed [DATA_W-1:0] high;
        logic                     swap;
    } t_cmpx;

endpackage

`default_nettype wire

@@ hw/rtl/bsa_cmpx.sv @@
// Compare-exchange unit shared by every step of every bubble pass.
// Depends on bsa_pkg.
`default_nettype none

module bsa_cmpx (
    input  wire logic signed [bsa_pkg::DATA_W-1:0] i_carry,
    input  wire logic signed [bsa_pkg::DATA_W-1:0] i_next,
    output bsa_pkg::t_cmpx                         o_res
);
    import bsa_pkg::*;

    logic w_gt;

    // Strictly greater: equal neighbors stay in place
    assign w_gt = (i_carry > i_next);

    always_comb begin
        o_res.swap = w_gt;
        o_res.low  = w_gt ? i_next  : i_carry;
        o_res.high = w_gt ? i_carry : i_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/bubble_sort_ascending.sv @@
// Top level of the ascending bubble sorter: element memory, pass sequencer, output.
// Depends on bsa_pkg and bsa_cmpx.
`default_nettype none

// Collects a set of signed 32-bit values, one per item, and returns them in
// ascending order. An item is taken on a clock edge with start high and busy
// low; busy stays low while loading, so items may follow one another without
// a wait. The item with last_item set closes the set and raises busy. With n
// stored elements the sequencer then runs bubble passes over the element
// memory (one write port, one read port): each pass reads one element per
// cycle and carries the larger of each neighbor pair forward through one
// compare-exchange unit, writing the smaller back. Passes repeat until one
// makes no exchange (at most n passes, none for a single element). The
// results then leave at one per cycle, each shown for exactly one cycle with
// o_strobe; there is no backpressure, so the receiver must take every result
// when strobed. busy drops in the cycle the final result is shown, so a new
// set may start loading then. Elements beyond DEPTH are dropped and every
// result of that set carries overflow. No clearing pass after reset: only
// entries written in the current set are used.
module bubble_sort_ascending #(
    parameter int DEPTH = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output      logic             busy,
    input  wire bsa_pkg::t_item   i_item,
    output      logic             o_strobe,
    output      bsa_pkg::t_result o_result
);
    import bsa_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Element memory, one write and one registered read per cycle
    logic [DATA_W-1:0]        r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rdata;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count;     // elements stored in the open set
    logic [CW-1:0]            r_n;         // elements in the set being sorted
    logic                     r_dropped;
    logic [AW-1:0]            r_idx;
    logic signed [DATA_W-1:0] r_carry;     // larger value moving up this pass
    logic                     r_swapped;
    logic                     r_out_vld;
    logic                     r_out_last;
    logic                     r_out_ovf;

    logic                     w_accept;
    logic                     w_room;
    logic [CW-1:0]            w_n_final;
    logic [CW-1:0]            w_nm1;
    logic                     w_at_end;
    logic                     w_we;
    logic [AW-1:0]            w_wa;
    logic [DATA_W-1:0]        w_wd;
    logic [AW-1:0]            w_ra;
    t_cmpx                    w_cx;

    assign busy      = (r_state != S_IDLE);
    assign w_accept  = start && !busy;
    assign w_room    = (r_count < CW'(DEPTH));
    assign w_n_final = w_room ? (r_count + CW'(1)) : r_count;
    assign w_nm1     = r_n - CW'(1);
    assign w_at_end  = (CW'(r_idx) == w_nm1);

    bsa_cmpx u_cmpx (
        .i_carry (r_carry),
        .i_next  (r_rdata),
        .o_res   (w_cx)
    );

    // Memory port steering
    always_comb begin
        w_we = 1'b0;
        w_wa = r_count[AW-1:0];
        w_wd = i_item.value;
        w_ra = r_idx;
        unique case (r_state)
            S_IDLE: begin
                w_we = w_accept && w_room;
            end
            S_RD0: begin
                w_ra = '0;
            end
            S_LD: begin
                w_ra = r_idx;
            end
            S_RUN: begin
                w_we = 1'b1;
                w_wa = r_idx - AW'(1);
                w_wd = w_cx.low;
                w_ra = r_idx + AW'(1);
            end
            S_END: begin
                w_we = 1'b1;
                w_wa = w_nm1[AW-1:0];
                w_wd = r_carry;
            end
            S_OUT: begin
                w_ra = r_idx;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rdata <= r_mem[w_ra];
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_item.last_item) begin
                    n_state = (w_n_final > CW'(1)) ? S_RD0 : S_OUT;
                end
            end
            S_RD0:  n_state = S_LD;
            S_LD:   n_state = S_RUN;
            S_RUN: begin
                if (w_at_end) begin
                    n_state = S_END;
                end
            end
            S_END:  n_state = r_swapped ? S_RD0 : S_OUT;
            S_OUT: begin
                if (w_at_end) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_n       <= '0;
            r_dropped <= 1'b0;
            r_idx     <= '0;
            r_swapped <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_room) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_dropped <= 1'b1;
                        end
                        if (i_item.last_item) begin
                            r_n   <= w_n_final;
                            r_idx <= '0;
                        end
                    end
                end
                S_RD0: begin
                    r_idx <= AW'(1);
                end
                S_LD: begin
                    r_swapped <= 1'b0;
                end
                S_RUN: begin
                    if (w_cx.swap) begin
                        r_swapped <= 1'b1;
                    end
                    if (!w_at_end) begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                S_END: begin
                    r_idx <= '0;
                end
                S_OUT: begin
                    r_out_vld <= 1'b1;
                    if (w_at_end) begin
                        r_count   <= '0;
                        r_dropped <= 1'b0;
                        r_idx     <= '0;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                default: begin
                    r_out_vld <= 1'b0;
                end
            endcase
        end
    end

    // Carry register and result flags (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (r_state == S_LD) begin
            r_carry <= r_rdata;
        end else if (r_state == S_RUN) begin
            r_carry <= w_cx.high;
        end
        if (r_state == S_OUT) begin
            r_out_last <= w_at_end;
            r_out_ovf  <= r_dropped;
        end
    end

    assign o_strobe              = r_out_vld;
    assign o_result.sorted_value = r_rdata;
    assign o_result.last_result  = r_out_last;
    assign o_result.overflow     = r_out_ovf;

`ifndef SYNTHESIS
    a_strobe_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_OUT))
        else $error("result strobe without output phase");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count beyond depth");

    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last_result) |-> busy)
        else $error("idle before final result");

    a_sort_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD0) |-> (r_n > CW'(1)))
        else $error("sort pass on fewer than two elements");

    a_run_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> ((CW'(r_idx) < r_n) && (r_idx != '0)))
        else $error("pass index out of range");
`endif

endmodule

`default_nettype wire
